>>> hdl/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants, codes and types of the line sensor centroid block.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int CHANNELS  = 8;
    localparam int CH_W      = 3;
    localparam int IDX_W     = $clog2(CHANNELS);
    localparam int CNT_W     = $clog2(CHANNELS + 1);
    localparam int SAMPLE_W  = 12;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 15;
    localparam int ERR_W     = 16;

    // sum of all entries, weighted sum, centroid dividend
    localparam int SUM_W     = SAMPLE_W + IDX_W;
    localparam int WSUM_W    = SUM_W + IDX_W;
    localparam int NUM_W     = WSUM_W + SAMPLE_W;
    localparam int DEN_W     = SUM_W;
    localparam int QUOT_W    = NUM_W - DEN_W;
    localparam int STEP_W    = $clog2(QUOT_W);

    localparam logic [POS_W-1:0] TARGET_RESET = POS_W'(14332);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HIGH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HIGH = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = CFG_IDX_W'(4);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_NSTART,
        S_NORM,
        S_WRITE,
        S_SUM,
        S_SUM_END,
        S_CENT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
    } t_cal;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                wr_en;
        logic [IDX_W-1:0]    wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
    } t_store_req;

endpackage

>>> hdl/lsc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_cfg
// Calibration and setpoint registers with per-channel window lookup.
// ----------------------------------------------------------------------------
module lsc_cfg
    import lsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [CH_W-1:0]      i_channel,
    output t_cal                 o_cal,
    output logic [POS_W-1:0]     o_target
);

    logic [CFG_W-1:0] r_min_low;
    logic [CFG_W-1:0] r_min_high;
    logic [CFG_W-1:0] r_max_low;
    logic [CFG_W-1:0] r_max_high;
    logic [POS_W-1:0] r_target;
    logic [CFG_W-1:0] w_min_reg;
    logic [CFG_W-1:0] w_max_reg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_low  <= '0;
            r_min_high <= '0;
            r_max_low  <= '1;
            r_max_high <= '1;
            r_target   <= TARGET_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_LOW:  r_min_low  <= i_cfg_data;
                CFG_MIN_HIGH: r_min_high <= i_cfg_data;
                CFG_MAX_LOW:  r_max_low  <= i_cfg_data;
                CFG_MAX_HIGH: r_max_high <= i_cfg_data;
                CFG_TARGET:   r_target   <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // four channels per register, channel 0 and 4 in the low bits
    always_comb begin
        w_min_reg = i_channel[CH_W-1] ? r_min_high : r_min_low;
        w_max_reg = i_channel[CH_W-1] ? r_max_high : r_max_low;
        o_cal.lo  = w_min_reg[i_channel[CH_W-2:0] * SAMPLE_W +: SAMPLE_W];
        o_cal.hi  = w_max_reg[i_channel[CH_W-2:0] * SAMPLE_W +: SAMPLE_W];
    end

    assign o_target = r_target;

endmodule

>>> hdl/lsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_div
// Restoring divider, one quotient bit per cycle. The top DEN_W bits of the
// dividend must be below the divisor, so QUOT_W steps give the full quotient.
// ----------------------------------------------------------------------------
module lsc_div
    import lsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[QUOT_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = w_trial >= {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // dividend low bits shift out while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= i_req.num[NUM_W-1 -: DEN_W];
            r_quo <= i_req.num[QUOT_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUOT_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> hdl/lsc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_store
// Normalized value store: one write and one registered read per cycle.
// Entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module lsc_store
    import lsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_store_req          i_req,
    output logic [SAMPLE_W-1:0] o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    logic [SAMPLE_W-1:0] r_rd_raw;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_raw <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

>>> hdl/line_sensor_centroid.sv
`timescale 1ns / 1ps
// Each item passes preparation and a normalizing divide; an item that closes a
// frame adds an 8-entry store sweep and a second divide. The first divide is
// skipped when the channel's window is empty, the second when the store sums to zero.
// One item at a time: the next is taken once the result moves to the output
// register. The bit-serial divider and the one-entry-per-cycle store sweep
// set how long an item takes.
// Reset is synchronous and clears control, output valid and the store's valid bits together.
// ----------------------------------------------------------------------------
// line_sensor_centroid
// Per-channel sample normalization and weighted-centroid line position.
// ----------------------------------------------------------------------------
module line_sensor_centroid
    import lsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CH_W-1:0]         i_channel,
    input  logic [SAMPLE_W-1:0]     i_raw_sample,
    input  logic                    i_end_of_frame,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SAMPLE_W-1:0]     o_normalized,
    output logic [POS_W-1:0]        o_position,
    output logic signed [ERR_W-1:0] o_position_error,
    output logic                    o_frame_done,
    output logic                    o_zero_sum,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CHANNELS);

    t_state r_state;
    t_state n_state;

    logic [CH_W-1:0]      r_ch;
    logic [SAMPLE_W-1:0]  r_raw;
    logic                 r_eof;
    logic [SAMPLE_W-1:0]  r_diff;
    logic [SAMPLE_W-1:0]  r_range;
    logic                 r_empty;
    logic [SAMPLE_W-1:0]  r_norm;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_acc_en;
    logic [IDX_W-1:0]     r_acc_idx;
    logic [SUM_W-1:0]     r_sum;
    logic [WSUM_W-1:0]    r_wsum;
    logic [POS_W-1:0]     r_pos;
    logic                 r_zero;

    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_norm;
    logic [POS_W-1:0]     r_out_pos;
    logic [ERR_W-1:0]     r_out_err;
    logic                 r_out_done;
    logic                 r_out_zero;

    t_cal                 w_cal;
    logic [POS_W-1:0]     w_target;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;
    t_store_req           w_store_req;
    logic [SAMPLE_W-1:0]  w_rd_data;
    logic                 w_accept;
    logic                 w_out_load;
    logic [SAMPLE_W-1:0]  w_clamp;
    logic [2*SAMPLE_W-1:0] w_scaled;
    logic [NUM_W-1:0]     w_wscaled;
    logic [WSUM_W-1:0]    w_term;
    logic [ERR_W-1:0]     w_err;

    lsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_channel   (r_ch),
        .o_cal       (w_cal),
        .o_target    (w_target)
    );

    lsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lsc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_store_req),
        .o_rd_data (w_rd_data)
    );

    // datapath arithmetic
    always_comb begin
        w_clamp   = (r_raw > w_cal.hi) ? w_cal.hi : r_raw;
        w_clamp   = (w_clamp < w_cal.lo) ? w_cal.lo : w_clamp;
        // times 4095 as shift and subtract
        w_scaled  = {r_diff, SAMPLE_W'(0)} - {SAMPLE_W'(0), r_diff};
        w_wscaled = {r_wsum, SAMPLE_W'(0)} - {SAMPLE_W'(0), r_wsum};
        w_term    = WSUM_W'(r_acc_idx) * WSUM_W'(w_rd_data);
        w_err     = {1'b0, r_pos} - {1'b0, w_target};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:   n_state = S_NSTART;
            S_NSTART: n_state = r_empty ? S_WRITE : S_NORM;
            S_NORM: begin
                if (w_div_rsp.done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE:  n_state = r_eof ? S_SUM : S_DONE;
            S_SUM: begin
                if (r_cnt == CNT_END) begin
                    n_state = S_SUM_END;
                end
            end
            S_SUM_END: n_state = (r_sum == '0) ? S_DONE : S_CENT;
            S_CENT: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall             = (r_state != S_IDLE);
        w_accept            = (r_state == S_IDLE) && i_valid;
        w_out_load          = (r_state == S_DONE) && (!r_out_valid || !i_stall);
        w_div_req.start     = ((r_state == S_NSTART) && !r_empty) ||
                              ((r_state == S_SUM_END) && (r_sum != '0));
        w_div_req.num       = (r_state == S_NSTART) ? NUM_W'(w_scaled) : w_wscaled;
        w_div_req.den       = (r_state == S_NSTART) ? DEN_W'(r_range) : r_sum;
        w_store_req.wr_en   = (r_state == S_WRITE);
        w_store_req.wr_addr = r_ch;
        w_store_req.wr_data = r_norm;
        w_store_req.rd_en   = (r_state == S_SUM) && (r_cnt < CNT_END);
        w_store_req.rd_addr = r_cnt[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc_en <= w_store_req.rd_en;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch  <= i_channel;
            r_raw <= i_raw_sample;
            r_eof <= i_end_of_frame;
        end
        if (r_state == S_PREP) begin
            r_diff  <= w_clamp - w_cal.lo;
            r_range <= w_cal.hi - w_cal.lo;
            r_empty <= (w_cal.hi <= w_cal.lo);
            r_zero  <= 1'b0;
        end
        if ((r_state == S_NSTART) && r_empty) begin
            r_norm <= '0;
        end
        if ((r_state == S_NORM) && w_div_rsp.done) begin
            r_norm <= w_div_rsp.quot[SAMPLE_W-1:0];
        end
        if (r_state == S_WRITE) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_wsum <= '0;
        end
        if (w_store_req.rd_en) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_acc_idx <= r_cnt[IDX_W-1:0];
        if (r_acc_en) begin
            r_sum  <= r_sum + SUM_W'(w_rd_data);
            r_wsum <= r_wsum + w_term;
        end
        if ((r_state == S_SUM_END) && (r_sum == '0)) begin
            r_zero <= 1'b1;
            r_pos  <= '0;
        end
        if ((r_state == S_CENT) && w_div_rsp.done) begin
            r_pos <= w_div_rsp.quot;
        end
        if (w_out_load) begin
            r_out_norm <= r_norm;
            r_out_pos  <= r_eof ? r_pos : '0;
            r_out_err  <= r_eof ? w_err : '0;
            r_out_done <= r_eof;
            r_out_zero <= r_eof && r_zero;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_normalized     = r_out_norm;
    assign o_position       = r_out_pos;
    assign o_position_error = $signed(r_out_err);
    assign o_frame_done     = r_out_done;
    assign o_zero_sum       = r_out_zero;

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_NORM || r_state == S_CENT))
        else $error("divider finished outside a divide state");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_PREP))
        else $error("accepted item did not start preparation");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_cnt <= CNT_END))
        else $error("store sweep ran past the last entry");

    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_sum) |-> (o_frame_done && o_position == '0))
        else $error("zero sum result with nonzero position");

endmodule
